### rtl/core/five_bar_leg_ik_to_servo_pulse_defines.svh
// ----------------------------------------------------------------------------
// five_bar_leg_ik_to_servo_pulse_defines
// Assertion macros shared by the five-bar leg IK checker.
// ----------------------------------------------------------------------------
`ifndef FIVE_BAR_LEG_IK_TO_SERVO_PULSE_DEFINES_SVH
`define FIVE_BAR_LEG_IK_TO_SERVO_PULSE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FBIK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define FBIK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fbik_pkg.sv
// ----------------------------------------------------------------------------
// fbik_pkg
// Types, codes and tables of the five-bar leg IK block.
// ----------------------------------------------------------------------------
package fbik_pkg;

    localparam int MAC_STEPS = 16;
    localparam int SQ_STEPS  = 37;
    localparam int CFG_IW    = 3;

    localparam logic [CFG_IW-1:0] REG_LEFT_CRANK    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LEFT_COUPLER  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_RIGHT_COUPLER = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RIGHT_CRANK   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_HIP_SPACING   = 3'd4;

    localparam logic [1:0] SS_NEW    = 2'd0;
    localparam logic [1:0] SS_NOSOL  = 2'd1;
    localparam logic [1:0] SS_WINDOW = 2'd2;

    localparam logic [10:0] PULSE_CENTER = 11'd750;

    typedef enum logic [3:0] {
        MS_NONE, MS_XP, MS_YP, MS_XX, MS_YY, MS_PP, MS_QQ,
        MS_AHH, MS_AHL, MS_ALL, MS_BHH, MS_BHL, MS_BLL,
        MS_CHH, MS_CHL, MS_CLL
    } mul_sel_t;

    typedef enum logic [3:0] {
        AO_NONE, AO_A, AO_B, AO_C_SET, AO_C_ADD, AO_C_SUB,
        AO_S_SET_HI, AO_S_ADD_HI, AO_S_ADD_MID, AO_S_ADD_LO,
        AO_S_SUB_HI, AO_S_SUB_MID, AO_S_SUB_LO
    } acc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
    } mac_op_t;

    typedef struct packed {
        logic       load_in;
        logic       side;
        logic       mac_en;
        logic [3:0] step;
        logic       sqrt_init;
        logic       sqrt_en;
        logic       prep_en;
        logic       norm_en;
        logic       cordic_en;
        logic [5:0] iter;
        logic       store_en;
        logic       scale_en;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic s_neg;
        logic den_zero;
        logic norm_done;
    } sts_t;

    // product issued at step k is accumulated at step k+1
    function automatic mac_op_t mac_op(input logic [3:0] step);
        mac_op_t op;
        unique case (step)
            4'd0:  op = '{MS_XP,   AO_NONE};
            4'd1:  op = '{MS_YP,   AO_A};
            4'd2:  op = '{MS_XX,   AO_B};
            4'd3:  op = '{MS_YY,   AO_C_SET};
            4'd4:  op = '{MS_PP,   AO_C_ADD};
            4'd5:  op = '{MS_QQ,   AO_C_ADD};
            4'd6:  op = '{MS_AHH,  AO_C_SUB};
            4'd7:  op = '{MS_AHL,  AO_S_SET_HI};
            4'd8:  op = '{MS_ALL,  AO_S_ADD_MID};
            4'd9:  op = '{MS_BHH,  AO_S_ADD_LO};
            4'd10: op = '{MS_BHL,  AO_S_ADD_HI};
            4'd11: op = '{MS_BLL,  AO_S_ADD_MID};
            4'd12: op = '{MS_CHH,  AO_S_ADD_LO};
            4'd13: op = '{MS_CHL,  AO_S_SUB_HI};
            4'd14: op = '{MS_CLL,  AO_S_SUB_MID};
            4'd15: op = '{MS_NONE, AO_S_SUB_LO};
            default: op = '{MS_NONE, AO_NONE};
        endcase
        return op;
    endfunction

    // atan(2^-i) in degrees * 2^24
    function automatic logic [29:0] atan_deg24(input logic [4:0] i);
        logic [29:0] t;
        unique case (i)
            5'd0:  t = 30'd754974720;
            5'd1:  t = 30'd445687602;
            5'd2:  t = 30'd235489088;
            5'd3:  t = 30'd119537938;
            5'd4:  t = 30'd60000934;
            5'd5:  t = 30'd30029717;
            5'd6:  t = 30'd15018523;
            5'd7:  t = 30'd7509720;
            5'd8:  t = 30'd3754917;
            5'd9:  t = 30'd1877466;
            5'd10: t = 30'd938734;
            5'd11: t = 30'd469367;
            5'd12: t = 30'd234684;
            5'd13: t = 30'd117342;
            5'd14: t = 30'd58671;
            5'd15: t = 30'd29335;
            5'd16: t = 30'd14668;
            5'd17: t = 30'd7334;
            5'd18: t = 30'd3667;
            5'd19: t = 30'd1833;
            5'd20: t = 30'd917;
            5'd21: t = 30'd458;
            5'd22: t = 30'd229;
            5'd23: t = 30'd115;
            5'd24: t = 30'd57;
            5'd25: t = 30'd29;
            5'd26: t = 30'd14;
            5'd27: t = 30'd7;
            5'd28: t = 30'd4;
            5'd29: t = 30'd2;
            5'd30: t = 30'd1;
            5'd31: t = 30'd0;
            default: t = 30'd0;
        endcase
        return t;
    endfunction

endpackage

### rtl/core/fbik_ctrl.sv
// ----------------------------------------------------------------------------
// fbik_ctrl
// Sequencer: runs the multiply, square root, normalize and CORDIC phases
// for the left then the right hip, then scales and emits the result.
// ----------------------------------------------------------------------------
module fbik_ctrl #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output fbik_pkg::cmd_t cmd,
    input  fbik_pkg::sts_t sts
);
    import fbik_pkg::*;

    localparam logic [3:0] MAC_LAST    = 4'(MAC_STEPS - 1);
    localparam logic [5:0] SQ_LAST     = 6'(SQ_STEPS - 1);
    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_ITERATIONS - 1);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_MAC       = 10'b00_0000_0010,
        S_ROOT_INIT = 10'b00_0000_0100,
        S_SQRT      = 10'b00_0000_1000,
        S_PREP      = 10'b00_0001_0000,
        S_NORM      = 10'b00_0010_0000,
        S_CORDIC    = 10'b00_0100_0000,
        S_STORE     = 10'b00_1000_0000,
        S_SCALE     = 10'b01_0000_0000,
        S_EMIT      = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [5:0] iter_reg, iter_next;
    logic       side_reg, side_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        iter_next  = iter_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        cmd.step   = step_reg;
        cmd.iter   = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    side_next   = 1'b0;
                    step_next   = '0;
                    state_next  = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac_en = 1'b1;
                step_next  = step_reg + 4'd1;
                if (step_reg == MAC_LAST)
                    state_next = S_ROOT_INIT;
            end
            S_ROOT_INIT:
            begin
                if (sts.s_neg)
                    state_next = S_STORE;
                else
                begin
                    cmd.sqrt_init = 1'b1;
                    iter_next     = '0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_en = 1'b1;
                iter_next   = iter_reg + 6'd1;
                if (iter_reg == SQ_LAST)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep_en = 1'b1;
                state_next  = S_NORM;
            end
            S_NORM:
            begin
                priority if (sts.den_zero)
                    state_next = S_STORE;
                else if (sts.norm_done)
                begin
                    iter_next  = '0;
                    state_next = S_CORDIC;
                end
                else
                    cmd.norm_en = 1'b1;
            end
            S_CORDIC:
            begin
                cmd.cordic_en = 1'b1;
                iter_next     = iter_reg + 6'd1;
                if (iter_reg == CORDIC_LAST)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.store_en = 1'b1;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    step_next  = '0;
                    state_next = S_MAC;
                end
                else
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            iter_reg      <= '0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            iter_reg      <= iter_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/fbik_datapath.sv
// ----------------------------------------------------------------------------
// fbik_datapath
// Link registers, shared 20x20 multiplier with accumulators, bit-serial
// square root, CORDIC atan and the pulse scaling stage.
// ----------------------------------------------------------------------------
module fbik_datapath #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [fbik_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic signed [15:0]            in_x,
    input  logic signed [15:0]            in_y,
    input  fbik_pkg::cmd_t                cmd,
    output fbik_pkg::sts_t                sts,
    output logic [10:0]                   left_pulse,
    output logic [10:0]                   right_pulse,
    output logic [1:0]                    solve_status
);
    import fbik_pkg::*;

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int ZW  = F + 8;
    localparam int AW  = F + 10;
    localparam int PHW = F + 9;
    localparam int TW  = F + 6;
    localparam int WW  = AW + 7;
    localparam int MW  = 20;
    localparam int PRW = 40;
    localparam int CW  = 38;
    localparam int SW  = 78;
    localparam int NW  = 45;

    localparam logic signed [AW-1:0] DEG_90  = AW'(90) <<< F;
    localparam logic signed [AW-1:0] DEG_270 = AW'(270) <<< F;
    localparam logic signed [AW-1:0] DEG_360 = AW'(360) <<< F;
    localparam logic [PHW-1:0] PH_81  = PHW'(81) << F;
    localparam logic [PHW-1:0] PH_99  = PHW'(99) << F;
    localparam logic [PHW-1:0] PH_261 = PHW'(261) << F;
    localparam logic [PHW-1:0] PH_270 = PHW'(270) << F;
    localparam logic [PHW-1:0] PH_279 = PHW'(279) << F;
    localparam logic [NW-1:0]  NORM_LIM = NW'(1) << 40;

    logic [15:0] lcrank_reg, lcoup_reg, rcoup_reg, rcrank_reg, hip_reg;
    logic signed [15:0] x_reg, y_reg;

    logic signed [17:0] xs;
    logic signed [16:0] ys;
    logic [16:0] p_len, q_len;
    logic signed [MW-1:0] op_a, op_b;
    logic signed [PRW-1:0] prod_reg;
    logic signed [CW-1:0] a_reg, b_reg, c_reg;
    logic signed [SW-1:0] s_reg, p_ext;
    logic [CW-1:0] ma, mb, mc;
    mac_op_t op;

    logic [73:0] rad_reg;
    logic [38:0] rem_reg;
    logic [36:0] root_reg;
    logic [40:0] rem_sh, trial, rem_diff;
    logic sq_ge;

    logic signed [39:0] num40, den40;
    logic signed [NW-1:0] n_reg, d_reg, n_mag, dx, dy;
    logic signed [ZW-1:0] z_reg;
    logic [TW-1:0] t_ang;
    logic num_zero_reg, num_pos_reg, den_zero_reg;

    logic signed [AW-1:0] half, angle, wrapped;
    logic [PHW-1:0] phi_l_reg, phi_r_reg;
    logic [1:0] code_l_reg, code_r_reg, side_code;

    logic signed [AW-1:0] vl, vr;
    logic signed [WW-1:0] wl, wr;
    logic l_ok, r_ok;
    logic [1:0] stat_calc, stat_reg;
    logic [14:0] ul_reg, ur_reg;
    logic [30:0] pl, pr;

    logic [10:0] left_pulse_reg, right_pulse_reg;
    logic [1:0]  status_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcrank_reg <= 16'd3932;
            lcoup_reg  <= 16'd5898;
            rcoup_reg  <= 16'd5898;
            rcrank_reg <= 16'd3932;
            hip_reg    <= 16'd2490;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEFT_CRANK:    lcrank_reg <= cfg_data;
                REG_LEFT_COUPLER:  lcoup_reg  <= cfg_data;
                REG_RIGHT_COUPLER: rcoup_reg  <= cfg_data;
                REG_RIGHT_CRANK:   rcrank_reg <= cfg_data;
                REG_HIP_SPACING:   hip_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        xs    = cmd.side ? (18'(x_reg) <<< 1) - 18'({2'b00, hip_reg})
                         : (18'(x_reg) <<< 1) + 18'({2'b00, hip_reg});
        ys    = {y_reg, 1'b0};
        p_len = cmd.side ? {rcrank_reg, 1'b0} : {lcrank_reg, 1'b0};
        q_len = cmd.side ? {rcoup_reg, 1'b0}  : {lcoup_reg, 1'b0};
        ma    = a_reg[CW-1] ? -a_reg : a_reg;
        mb    = b_reg[CW-1] ? -b_reg : b_reg;
        mc    = c_reg[CW-1] ? -c_reg : c_reg;
        op    = mac_op(cmd.step);
        unique case (op.mul_sel)
            MS_XP:  begin op_a = MW'(xs);            op_b = MW'(p_len); end
            MS_YP:  begin op_a = MW'(ys);            op_b = MW'(p_len); end
            MS_XX:  begin op_a = MW'(xs);            op_b = MW'(xs); end
            MS_YY:  begin op_a = MW'(ys);            op_b = MW'(ys); end
            MS_PP:  begin op_a = MW'(p_len);         op_b = MW'(p_len); end
            MS_QQ:  begin op_a = MW'(q_len);         op_b = MW'(q_len); end
            MS_AHH: begin op_a = MW'(ma[36:19]);     op_b = MW'(ma[36:19]); end
            MS_AHL: begin op_a = MW'(ma[36:19]);     op_b = MW'(ma[18:0]); end
            MS_ALL: begin op_a = MW'(ma[18:0]);      op_b = MW'(ma[18:0]); end
            MS_BHH: begin op_a = MW'(mb[36:19]);     op_b = MW'(mb[36:19]); end
            MS_BHL: begin op_a = MW'(mb[36:19]);     op_b = MW'(mb[18:0]); end
            MS_BLL: begin op_a = MW'(mb[18:0]);      op_b = MW'(mb[18:0]); end
            MS_CHH: begin op_a = MW'(mc[36:19]);     op_b = MW'(mc[36:19]); end
            MS_CHL: begin op_a = MW'(mc[36:19]);     op_b = MW'(mc[18:0]); end
            MS_CLL: begin op_a = MW'(mc[18:0]);      op_b = MW'(mc[18:0]); end
            default: begin op_a = '0;                op_b = '0; end
        endcase
        p_ext = SW'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        if (cmd.mac_en)
        begin
            prod_reg <= PRW'(op_a) * PRW'(op_b);
            unique case (op.acc_op)
                AO_A:         a_reg <= CW'(prod_reg) <<< 1;
                AO_B:         b_reg <= CW'(prod_reg) <<< 1;
                AO_C_SET:     c_reg <= CW'(prod_reg);
                AO_C_ADD:     c_reg <= c_reg + CW'(prod_reg);
                AO_C_SUB:     c_reg <= c_reg - CW'(prod_reg);
                AO_S_SET_HI:  s_reg <= p_ext <<< 38;
                AO_S_ADD_HI:  s_reg <= s_reg + (p_ext <<< 38);
                AO_S_ADD_MID: s_reg <= s_reg + (p_ext <<< 20);
                AO_S_ADD_LO:  s_reg <= s_reg + p_ext;
                AO_S_SUB_HI:  s_reg <= s_reg - (p_ext <<< 38);
                AO_S_SUB_MID: s_reg <= s_reg - (p_ext <<< 20);
                AO_S_SUB_LO:  s_reg <= s_reg - p_ext;
                default: ;
            endcase
        end
    end

    // restoring square root, one result bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[73:72]};
        trial    = {2'b00, root_reg, 2'b01};
        sq_ge    = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rad_reg  <= s_reg[73:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_en)
        begin
            rad_reg  <= {rad_reg[71:0], 2'b00};
            rem_reg  <= sq_ge ? rem_diff[38:0] : rem_sh[38:0];
            root_reg <= {root_reg[35:0], sq_ge};
        end
    end

    always_comb
    begin
        num40 = cmd.side ? 40'(b_reg) - 40'(root_reg) : 40'(b_reg) + 40'(root_reg);
        den40 = 40'(a_reg) + 40'(c_reg);
        n_mag = n_reg[NW-1] ? -n_reg : n_reg;
        dx    = n_reg >>> cmd.iter[4:0];
        dy    = d_reg >>> cmd.iter[4:0];
        t_ang = TW'(atan_deg24(cmd.iter[4:0]) >> (24 - F));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep_en)
        begin
            n_reg        <= den40[39] ? -NW'(num40) : NW'(num40);
            d_reg        <= den40[39] ? -NW'(den40) : NW'(den40);
            num_zero_reg <= (num40 == '0);
            num_pos_reg  <= !num40[39] && (num40 != '0);
            den_zero_reg <= (den40 == '0);
            z_reg        <= '0;
        end
        else if (cmd.norm_en)
        begin
            n_reg <= n_reg <<< 1;
            d_reg <= d_reg <<< 1;
        end
        else if (cmd.cordic_en)
        begin
            if (!n_reg[NW-1])
            begin
                d_reg <= d_reg + dx;
                n_reg <= n_reg - dy;
                z_reg <= z_reg + ZW'(t_ang);
            end
            else
            begin
                d_reg <= d_reg - dx;
                n_reg <= n_reg + dy;
                z_reg <= z_reg - ZW'(t_ang);
            end
        end
    end

    assign sts.s_neg     = s_reg[SW-1];
    assign sts.den_zero  = den_zero_reg;
    assign sts.norm_done = (n_mag >= NORM_LIM) || (d_reg >= NORM_LIM);

    always_comb
    begin
        if (den_zero_reg)
            half = num_pos_reg ? DEG_90 : -DEG_90;
        else
            half = AW'(z_reg);
        angle   = half <<< 1;
        wrapped = angle[AW-1] ? angle + DEG_360 : angle;
        priority if (s_reg[SW-1])
            side_code = SS_NOSOL;
        else if (den_zero_reg && num_zero_reg)
            side_code = SS_WINDOW;
        else
            side_code = SS_NEW;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_en)
        begin
            if (cmd.side)
            begin
                phi_r_reg  <= PHW'(wrapped);
                code_r_reg <= side_code;
            end
            else
            begin
                phi_l_reg  <= PHW'(wrapped);
                code_l_reg <= side_code;
            end
        end
    end

    // pulse = 250 + floor(v * 1000 / 180 deg); v*50 >> F, then divide by 9
    always_comb
    begin
        vl   = DEG_270 - AW'(phi_l_reg);
        vr   = (phi_r_reg >= PH_270) ? AW'(phi_r_reg) - DEG_270 : AW'(phi_r_reg) + DEG_90;
        wl   = WW'(vl) * WW'(50);
        wr   = WW'(vr) * WW'(50);
        l_ok = (phi_l_reg >= PH_99) && (phi_l_reg <= PH_261);
        r_ok = (phi_r_reg >= PH_279) || (phi_r_reg <= PH_81);
        priority if (code_l_reg == SS_NOSOL || code_r_reg == SS_NOSOL)
            stat_calc = SS_NOSOL;
        else if (code_l_reg == SS_WINDOW || code_r_reg == SS_WINDOW || !l_ok || !r_ok)
            stat_calc = SS_WINDOW;
        else
            stat_calc = SS_NEW;
        pl = 31'(ul_reg) * 31'(58255);
        pr = 31'(ur_reg) * 31'(58255);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale_en)
        begin
            ul_reg   <= 15'(wl >>> F);
            ur_reg   <= 15'(wr >>> F);
            stat_reg <= stat_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pulse_reg  <= PULSE_CENTER;
            right_pulse_reg <= PULSE_CENTER;
            status_out_reg  <= SS_NEW;
        end
        else if (cmd.out_load)
        begin
            status_out_reg <= stat_reg;
            if (stat_reg == SS_NEW)
            begin
                left_pulse_reg  <= 11'(12'd250 + pl[30:19]);
                right_pulse_reg <= 11'(12'd250 + pr[30:19]);
            end
        end
    end

    assign left_pulse   = left_pulse_reg;
    assign right_pulse  = right_pulse_reg;
    assign solve_status = status_out_reg;

endmodule

### rtl/core/five_bar_leg_ik_to_servo_pulse.sv
// ----------------------------------------------------------------------------
// five_bar_leg_ik_to_servo_pulse
// Five-bar leg inverse kinematics from a foot target to two servo pulses.
// ----------------------------------------------------------------------------
// One request at a time. Each hip side runs the steps on the shared
// multiplier, the bit-serial square root, the normalizing shift and the
// CORDIC iterations; a side with no real solution skips all but the
// multiplier steps. Then both sides are scaled and the result is output.
// The result sits in an output register, so a new request is taken while it
// waits. Config writes are always accepted.
module five_bar_leg_ik_to_servo_pulse #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_position[15:0], y_position[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // left_pulse[10:0], right_pulse[21:11], zero
    output logic [1:0]  m_axis_tuser,   // solve_status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fbik_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [10:0] left_pulse, right_pulse;

    fbik_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    fbik_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_x        (s_axis_tdata[15:0]),
        .in_y        (s_axis_tdata[31:16]),
        .cmd         (cmd),
        .sts         (sts),
        .left_pulse  (left_pulse),
        .right_pulse (right_pulse),
        .solve_status(m_axis_tuser)
    );

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b00, right_pulse, left_pulse};

endmodule

### rtl/core/fbik_port_checker.sv
// ----------------------------------------------------------------------------
// fbik_port_checker
// Port-level checks of the five-bar leg IK block, bound to the top level.
// ----------------------------------------------------------------------------
`include "five_bar_leg_ik_to_servo_pulse_defines.svh"

module fbik_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import fbik_pkg::*;

    logic [10:0] last_l_reg, last_r_reg;
    logic [21:0] held_pair;
    logic        out_take;

    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign held_pair = {last_r_reg, last_l_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_l_reg <= PULSE_CENTER;
            last_r_reg <= PULSE_CENTER;
        end
        else if (out_take)
        begin
            last_l_reg <= m_axis_tdata[10:0];
            last_r_reg <= m_axis_tdata[21:11];
        end
    end

    `FBIK_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")
    `FBIK_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tuser == SS_NEW || m_axis_tuser == SS_NOSOL || m_axis_tuser == SS_WINDOW), "bad solve status")
    `FBIK_ASSERT(a_held_pulses, m_axis_tvalid && m_axis_tuser != SS_NEW |-> m_axis_tdata[21:0] == held_pair, "held pulses changed")
    `FBIK_ASSERT(a_pulse_range, m_axis_tvalid && m_axis_tuser == SS_NEW |-> m_axis_tdata[10:0] >= 11'd250 && m_axis_tdata[10:0] <= 11'd1250 && m_axis_tdata[21:11] >= 11'd250 && m_axis_tdata[21:11] <= 11'd1250, "pulse out of range")

endmodule

bind five_bar_leg_ik_to_servo_pulse fbik_port_checker u_port_checker (.*);

### test/five_bar_leg_ik_to_servo_pulse_tb.sv
// ----------------------------------------------------------------------------
// five_bar_leg_ik_to_servo_pulse_tb
// Drives foot targets and link settings into the five-bar leg IK block and
// checks every pulse pair and status against an in-bench IK solver or a table.
// ----------------------------------------------------------------------------
module five_bar_leg_ik_to_servo_pulse_tb;
    import fbik_pkg::*;

    localparam int    FRAC_BITS   = 16;
    localparam int    ATAN_STEPS  = 16;
    localparam longint ONE_DEG    = longint'(1) << FRAC_BITS;
    localparam longint NORM_LIMIT = longint'(1) << 40;
    localparam int    STALL_LIMIT = 12000;

    localparam longint ATAN_DEG24 [ATAN_STEPS] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335
    };

    typedef struct {
        logic [10:0] left;
        logic [10:0] right;
        logic [1:0]  status;
    } servo_result_t;

    typedef struct {
        int          x;
        int          y;
        bit          typed;
        servo_result_t want;
    } target_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    longint left_crank, left_coupler, right_coupler, right_crank, hip_gap;
    logic [10:0] held_left, held_right;

    servo_result_t pending_pulses[$];
    int errors;
    int src_idle_pct;
    int dst_idle_pct;
    int hold_req;
    int hold_left;
    int stall_cycles;

    // held pulses from reset are all 750, so unreachable targets are obvious
    target_row_t directed_rows[18] = '{
        '{32767, 32767, 1'b1, '{11'd750, 11'd750, SS_NOSOL}},
        '{-32768, -32768, 1'b1, '{11'd750, 11'd750, SS_NOSOL}},
        '{-32768, 32767, 1'b1, '{11'd750, 11'd750, SS_NOSOL}},
        '{32767, -32768, 1'b1, '{11'd750, 11'd750, SS_NOSOL}},
        '{0, 0, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{0, -6000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{0, 6000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{-5177, 5898, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{-5177, -5898, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{1000, -7000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{-3000, -5000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{3000, -5000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{0, -9800, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{0, -2000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{5000, 5000, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{-1, -1, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{0, -32768, 1'b0, '{11'd0, 11'd0, SS_NEW}},
        '{-1245, -8000, 1'b0, '{11'd0, 11'd0, SS_NEW}}
    };

    five_bar_leg_ik_to_servo_pulse u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint hip_atan(longint num, longint den);
        longint n, d, m, z, dx, dy;
        n = num;
        d = den;
        z = 0;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        m = (n < 0) ? -n : n;
        if (d > m)
            m = d;
        while (m < NORM_LIMIT)
        begin
            m = m * 2;
            n = n * 2;
            d = d * 2;
        end
        for (int i = 0; i < ATAN_STEPS; i++)
        begin
            dx = n >>> i;
            dy = d >>> i;
            if (n >= 0)
            begin
                d = d + dx;
                n = n - dy;
                z = z + (ATAN_DEG24[i] >>> (24 - FRAC_BITS));
            end
            else
            begin
                d = d - dx;
                n = n + dy;
                z = z - (ATAN_DEG24[i] >>> (24 - FRAC_BITS));
            end
        end
        return z;
    endfunction

    function automatic logic [1:0] hip_angle(longint xs, longint ys, longint crank,
                                             longint coupler, bit neg_root,
                                             output longint angle);
        longint p, q, a, b, c, num, den, half;
        logic signed [131:0] aw, bw, cw, disc, root, trial;
        angle = 0;
        p = 2 * crank;
        q = 2 * coupler;
        a = 2 * xs * p;
        b = 2 * ys * p;
        c = xs * xs + ys * ys + p * p - q * q;
        aw = a;
        bw = b;
        cw = c;
        disc = aw * aw + bw * bw - cw * cw;
        if (disc < 0)
            return SS_NOSOL;
        root = 0;
        for (int k = 36; k >= 0; k--)
        begin
            trial = root;
            trial[k] = 1'b1;
            if (trial * trial <= disc)
                root = trial;
        end
        num = neg_root ? b - longint'(root[63:0]) : b + longint'(root[63:0]);
        den = a + c;
        if (den == 0)
        begin
            if (num == 0)
                return SS_WINDOW;
            half = (num > 0) ? 90 * ONE_DEG : -90 * ONE_DEG;
        end
        else
            half = hip_atan(num, den);
        angle = 2 * half;
        if (angle < 0)
            angle = angle + 360 * ONE_DEG;
        return SS_NEW;
    endfunction

    function automatic servo_result_t solve_pulses(shortint x, shortint y);
        servo_result_t res;
        longint phi1, phi4;
        logic [1:0] s1, s4;
        s1 = hip_angle(2 * longint'(x) + hip_gap, 2 * longint'(y), left_crank,
                       left_coupler, 1'b0, phi1);
        s4 = hip_angle(2 * longint'(x) - hip_gap, 2 * longint'(y), right_crank,
                       right_coupler, 1'b1, phi4);
        if (s1 == SS_NOSOL || s4 == SS_NOSOL)
            res.status = SS_NOSOL;
        else if (s1 == SS_WINDOW || s4 == SS_WINDOW
                 || phi1 < 99 * ONE_DEG || phi1 > 261 * ONE_DEG
                 || (phi4 < 279 * ONE_DEG && phi4 > 81 * ONE_DEG))
            res.status = SS_WINDOW;
        else
        begin
            res.status = SS_NEW;
            held_left = 11'(250 + (270 * ONE_DEG - phi1) * 1000 / (180 * ONE_DEG));
            if (phi4 >= 270 * ONE_DEG)
                held_right = 11'(250 + (phi4 - 270 * ONE_DEG) * 1000 / (180 * ONE_DEG));
            else
                held_right = 11'(250 + (90 * ONE_DEG + phi4) * 1000 / (180 * ONE_DEG));
        end
        res.left = held_left;
        res.right = held_right;
        return res;
    endfunction

    task automatic send_target(int x, int y, bit typed, servo_result_t typed_want);
        servo_result_t want;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y[15:0], x[15:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = solve_pulses(shortint'(x), shortint'(y));
        pending_pulses.push_back(typed ? typed_want : want);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEFT_CRANK:    left_crank = val;
            REG_LEFT_COUPLER:  left_coupler = val;
            REG_RIGHT_COUPLER: right_coupler = val;
            REG_RIGHT_CRANK:   right_crank = val;
            REG_HIP_SPACING:   hip_gap = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_links(int lc, int lq, int rq, int rc, int hip);
        wait_drained();
        write_reg(REG_LEFT_CRANK, 16'(lc));
        write_reg(REG_LEFT_COUPLER, 16'(lq));
        write_reg(REG_RIGHT_COUPLER, 16'(rq));
        write_reg(REG_RIGHT_CRANK, 16'(rc));
        write_reg(REG_HIP_SPACING, 16'(hip));
    endtask

    function automatic int clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    // mostly targets inside the reach of the left leg, some full-range noise
    task automatic run_random(int count, int phase);
        longint reach;
        int x, y;
        servo_result_t none;
        none = '{11'd0, 11'd0, SS_NEW};
        for (int i = 0; i < count; i++)
        begin
            reach = left_crank + left_coupler + 1;
            if (reach > 40000)
                reach = 40000;
            if ($urandom_range(0, 3) == 0)
            begin
                x = $signed(16'($urandom));
                y = $signed(16'($urandom));
            end
            else
            begin
                x = clip16(longint'($urandom_range(0, 2 * reach)) - reach);
                y = clip16(-longint'($urandom_range(0, reach)));
                if ($urandom_range(0, 4) == 0)
                    y = -y;
            end
            if (phase == 1 && i == 60)
                hold_req = 3000;
            if (phase == 3 && i == count / 2)
                wait_drained();
            send_target(x, y, 1'b0, none);
        end
    endtask

    always @(posedge clk)
    begin : check_pulses
        servo_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_pulses.size() == 0)
                begin
                    $error("pulse result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_pulses.pop_front();
                    if (m_axis_tdata[10:0] !== want.left)
                    begin
                        $error("left_pulse expected %0d got %0d", want.left,
                               m_axis_tdata[10:0]);
                        errors++;
                    end
                    if (m_axis_tdata[21:11] !== want.right)
                    begin
                        $error("right_pulse expected %0d got %0d", want.right,
                               m_axis_tdata[21:11]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("solve_status expected %0d got %0d", want.status,
                               m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("five_bar_leg_ik_to_servo_pulse_tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        servo_result_t none;
        none = '{11'd0, 11'd0, SS_NEW};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        hold_req = 0;
        hold_left = 0;
        stall_cycles = 0;
        src_idle_pct = 14;
        dst_idle_pct = 46;
        left_crank = 3932;
        left_coupler = 5898;
        right_coupler = 5898;
        right_crank = 3932;
        hip_gap = 2490;
        held_left = PULSE_CENTER;
        held_right = PULSE_CENTER;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_target(directed_rows[i].x, directed_rows[i].y, directed_rows[i].typed,
                        directed_rows[i].want);

        // unused indexes, then a fully collapsed linkage
        wait_drained();
        write_reg(3'd5, 16'($urandom));
        write_reg(3'd6, 16'($urandom));
        write_reg(3'd7, 16'($urandom));
        send_target(0, -6000, 1'b0, none);
        set_links(0, 0, 0, 0, 0);
        send_target(0, 0, 1'b0, none);
        send_target(100, -100, 1'b0, none);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_links(3932, 5898, 5898, 3932, 2490);
                1: set_links(65535, 65535, 65535, 65535, 0);
                2: set_links(1, 1, 1, 1, 65535);
                3: set_links($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
                4: set_links($urandom_range(2000, 9000), $urandom_range(3000, 12000),
                             $urandom_range(3000, 12000), $urandom_range(2000, 9000),
                             $urandom_range(0, 6000));
                default: set_links(12000, 18000, 18000, 12000, 7000);
            endcase
            src_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 46 : 0;
            dst_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 14 : 0;
            run_random(220, phase);
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("five_bar_leg_ik_to_servo_pulse_tb passed");
        else
            $display("five_bar_leg_ik_to_servo_pulse_tb failed");
        $finish;
    end
endmodule

### five_bar_leg_ik_to_servo_pulse.f
+incdir+rtl/core
rtl/core/fbik_pkg.sv
rtl/core/fbik_ctrl.sv
rtl/core/fbik_datapath.sv
rtl/core/five_bar_leg_ik_to_servo_pulse.sv
rtl/core/fbik_port_checker.sv
test/five_bar_leg_ik_to_servo_pulse_tb.sv
